// ===== hdl/wavhp_pkg.sv =====
// Package: transaction types and constants for the WAV header parser.
`timescale 1ns / 1ps

package wavhp_pkg;

    localparam int unsigned MIN_FILE_BYTES = 44;
    localparam int unsigned FMT_MIN_SIZE   = 16;

    localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
    localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
    localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA  = 32'h6174_6164;

    localparam logic [1:0] REASON_OK      = 2'd0;
    localparam logic [1:0] REASON_HEADER  = 2'd1;
    localparam logic [1:0] REASON_OVERRUN = 2'd2;
    localparam logic [1:0] REASON_FORMAT  = 2'd3;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  reason;
        logic [31:0] sample_rate;
        logic [30:0] frame_count;
        logic [31:0] data_offset;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } step_t;

endpackage

// ===== hdl/wavhp_in_stage.sv =====
// Input register stage: holds one byte transaction for the parser.
`timescale 1ns / 1ps

module wavhp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  wavhp_pkg::in_item_t byte_item,
    output logic               byte_stall,
    input  logic               out_free,
    output wavhp_pkg::step_t   step,
    output logic               fire
);
    import wavhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     hold;

    // only a last byte needs room in the result register
    assign hold       = valid_reg && item_reg.is_last && !out_free;
    assign byte_stall = hold;
    assign fire       = valid_reg && !hold;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && !byte_stall)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_reg <= byte_item;
        end
    end

    assign step.valid = valid_reg;
    assign step.item  = item_reg;

endmodule

// ===== hdl/wavhp_parser.sv =====
// Parser core: RIFF/WAVE checks, chunk walk, fmt/data capture and verdict.
`timescale 1ns / 1ps

module wavhp_parser #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  wavhp_pkg::step_t     step,
    output wavhp_pkg::out_item_t result
);
    import wavhp_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [POSITION_BITS-1:0] SHORT_POS = POSITION_BITS'(MIN_FILE_BYTES - 1);
    localparam logic [POSITION_BITS-3:0] WAVE_QUAD = (POSITION_BITS-2)'(2);
    localparam logic [POSITION_BITS-3:0] CHNK_QUAD = (POSITION_BITS-2)'(3);

    logic [POSITION_BITS-1:0] pos_reg,        pos_next;
    logic [2:0]               hdr_idx_reg,    hdr_idx_next;
    logic                     riff_ok_reg,    riff_ok_next;
    logic [31:0]              chunk_id_reg,   chunk_id_next;
    logic [31:0]              chunk_size_reg, chunk_size_next;
    logic [31:0]              left_reg,       left_next;
    logic                     pad_reg,        pad_next;
    logic                     fmt_active_reg, fmt_active_next;
    logic [4:0]               fmt_idx_reg,    fmt_idx_next;
    logic [15:0]              format_reg,     format_next;
    logic [15:0]              chans_reg,      chans_next;
    logic [31:0]              rate_reg,       rate_next;
    logic [15:0]              bits_reg,       bits_next;
    logic [POSITION_BITS-1:0] dstart_reg,     dstart_next;
    logic [31:0]              dlen_reg,       dlen_next;

    // stepped values before the end-of-file clear
    logic [POSITION_BITS-1:0] pos_inc;
    logic [2:0]               hdr_idx_s;
    logic                     riff_ok_s;
    logic [31:0]              chunk_id_s, chunk_size_s, left_s;
    logic                     pad_s, fmt_active_s;
    logic [4:0]               fmt_idx_s;
    logic [15:0]              format_s, chans_s, bits_s;
    logic [31:0]              rate_s, dlen_s;
    logic [POSITION_BITS-1:0] dstart_s;

    logic [7:0]               b;
    logic [POSITION_BITS-3:0] quad;
    logic [1:0]               reason;
    logic                     ok;

    assign b       = step.item.file_byte;
    assign quad    = pos_reg[POSITION_BITS-1:2];
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        hdr_idx_s    = hdr_idx_reg;
        riff_ok_s    = riff_ok_reg;
        chunk_id_s   = chunk_id_reg;
        chunk_size_s = chunk_size_reg;
        left_s       = left_reg;
        pad_s        = pad_reg;
        fmt_active_s = fmt_active_reg;
        fmt_idx_s    = fmt_idx_reg;
        format_s     = format_reg;
        chans_s      = chans_reg;
        rate_s       = rate_reg;
        bits_s       = bits_reg;
        dstart_s     = dstart_reg;
        dlen_s       = dlen_reg;

        if (quad == '0)
        begin
            if (b != RIFF_TAG[{pos_reg[1:0], 3'b000} +: 8])
            begin
                riff_ok_s = 1'b0;
            end
        end
        else if (quad == WAVE_QUAD)
        begin
            if (b != WAVE_TAG[{pos_reg[1:0], 3'b000} +: 8])
            begin
                riff_ok_s = 1'b0;
            end
        end
        else if (quad >= CHNK_QUAD)
        begin
            if (left_reg != '0)
            begin
                left_s = left_reg - 1'b1;
                if (fmt_active_reg && !fmt_idx_reg[4])
                begin
                    fmt_idx_s = fmt_idx_reg + 1'b1;
                    case (fmt_idx_reg[3:0])
                        4'd0:    format_s[7:0]   = b;
                        4'd1:    format_s[15:8]  = b;
                        4'd2:    chans_s[7:0]    = b;
                        4'd3:    chans_s[15:8]   = b;
                        4'd4:    rate_s[7:0]     = b;
                        4'd5:    rate_s[15:8]    = b;
                        4'd6:    rate_s[23:16]   = b;
                        4'd7:    rate_s[31:24]   = b;
                        4'd14:   bits_s[7:0]     = b;
                        4'd15:   bits_s[15:8]    = b;
                        default: ;
                    endcase
                end
            end
            else if (pad_reg)
            begin
                pad_s = 1'b0;
            end
            else
            begin
                if (hdr_idx_reg == 3'd0)
                begin
                    chunk_id_s   = '0;
                    chunk_size_s = '0;
                end
                if (!hdr_idx_reg[2])
                begin
                    chunk_id_s[{hdr_idx_reg[1:0], 3'b000} +: 8] = b;
                end
                else
                begin
                    chunk_size_s[{hdr_idx_reg[1:0], 3'b000} +: 8] = b;
                end
                hdr_idx_s = hdr_idx_reg + 1'b1;
                if (hdr_idx_reg == 3'd7)
                begin
                    left_s       = chunk_size_s;
                    pad_s        = chunk_size_s[0];
                    fmt_idx_s    = '0;
                    fmt_active_s = (chunk_id_s == ID_FMT) &&
                                   (chunk_size_s >= 32'(FMT_MIN_SIZE));
                    if (chunk_id_s == ID_DATA)
                    begin
                        dstart_s = pos_inc;
                        dlen_s   = chunk_size_s;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if ((pos_reg < SHORT_POS) || !riff_ok_s)
        begin
            reason = REASON_HEADER;
        end
        else if (left_s != '0)
        begin
            reason = REASON_OVERRUN;
        end
        else if ((format_s != 16'd1) || (chans_s != 16'd1) || (bits_s != 16'd16) ||
                 (rate_s == '0) || (dstart_s == '0) || (dlen_s < 32'd2))
        begin
            reason = REASON_FORMAT;
        end
        else
        begin
            reason = REASON_OK;
        end
        ok = (reason == REASON_OK);

        result.accepted    = ok;
        result.reason      = reason;
        result.sample_rate = ok ? rate_s : '0;
        result.frame_count = ok ? dlen_s[31:1] : '0;
        result.data_offset = ok ? 32'(dstart_s) : '0;
    end

    always_comb
    begin
        if (step.item.is_last)
        begin
            pos_next        = '0;
            hdr_idx_next    = '0;
            riff_ok_next    = 1'b1;
            chunk_id_next   = '0;
            chunk_size_next = '0;
            left_next       = '0;
            pad_next        = 1'b0;
            fmt_active_next = 1'b0;
            fmt_idx_next    = '0;
            format_next     = '0;
            chans_next      = '0;
            rate_next       = '0;
            bits_next       = '0;
            dstart_next     = '0;
            dlen_next       = '0;
        end
        else
        begin
            pos_next        = pos_inc;
            hdr_idx_next    = hdr_idx_s;
            riff_ok_next    = riff_ok_s;
            chunk_id_next   = chunk_id_s;
            chunk_size_next = chunk_size_s;
            left_next       = left_s;
            pad_next        = pad_s;
            fmt_active_next = fmt_active_s;
            fmt_idx_next    = fmt_idx_s;
            format_next     = format_s;
            chans_next      = chans_s;
            rate_next       = rate_s;
            bits_next       = bits_s;
            dstart_next     = dstart_s;
            dlen_next       = dlen_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            hdr_idx_reg    <= '0;
            riff_ok_reg    <= 1'b1;
            chunk_id_reg   <= '0;
            chunk_size_reg <= '0;
            left_reg       <= '0;
            pad_reg        <= 1'b0;
            fmt_active_reg <= 1'b0;
            fmt_idx_reg    <= '0;
            format_reg     <= '0;
            chans_reg      <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            dstart_reg     <= '0;
            dlen_reg       <= '0;
        end
        else if (fire)
        begin
            pos_reg        <= pos_next;
            hdr_idx_reg    <= hdr_idx_next;
            riff_ok_reg    <= riff_ok_next;
            chunk_id_reg   <= chunk_id_next;
            chunk_size_reg <= chunk_size_next;
            left_reg       <= left_next;
            pad_reg        <= pad_next;
            fmt_active_reg <= fmt_active_next;
            fmt_idx_reg    <= fmt_idx_next;
            format_reg     <= format_next;
            chans_reg      <= chans_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            dstart_reg     <= dstart_next;
            dlen_reg       <= dlen_next;
        end
    end

endmodule

// ===== hdl/wavhp_out_stage.sv =====
// Result register stage: holds the verdict transaction until taken.
`timescale 1ns / 1ps

module wavhp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  wavhp_pkg::out_item_t result,
    output logic                 out_free,
    output logic                 result_valid,
    input  logic                 result_stall,
    output wavhp_pkg::out_item_t result_item
);
    import wavhp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

// ===== hdl/wav_header_chunk_parser_unit.sv =====
// Top level: WAV header parser for mono 16-bit PCM files.
//
// Bytes of a WAV file arrive on the byte channel (byte_valid / byte_stall /
// byte_item), one transaction per byte in file order, is_last set on the
// final byte. For each file exactly one result transaction leaves on the
// result channel (result_valid / result_stall / result_item), giving the
// verdict, reason code, sample rate, frame count and data offset.
// A byte passes through an input register and the parser then updates its
// state from that register; the result of a last byte is loaded into the
// result register when the parser takes that byte. One byte per cycle is
// sustained while no last byte is held, limited only by the single parser
// state update per cycle; files may follow each other with no gap.
// Reset empties both registers and returns the parser to the start of file.
// While result_stall holds a waiting result, bytes that are not the last of
// a file still flow in; a last byte is held in the input register and
// byte_stall rises until the result register frees.
`timescale 1ns / 1ps

module wav_header_chunk_parser_unit #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  wavhp_pkg::in_item_t  byte_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output wavhp_pkg::out_item_t result_item
);
    import wavhp_pkg::*;

    step_t     step;
    logic      fire;
    logic      out_free;
    out_item_t result;

    wavhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_item  (byte_item),
        .byte_stall (byte_stall),
        .out_free   (out_free),
        .step       (step),
        .fire       (fire)
    );

    wavhp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .step   (step),
        .result (result)
    );

    wavhp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && step.item.is_last),
        .result       (result),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule
